>>> src/mpct_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpct_pkg
// Shared codes, constants and stage records of the mouse cursor tracker.
// ----------------------------------------------------------------------------
package mpct_pkg;

  // Input item sources.
  localparam logic [1:0] FUNC_PS2    = 2'd0;
  localparam logic [1:0] FUNC_BOOT   = 2'd1;
  localparam logic [1:0] FUNC_TABLET = 2'd2;

  // Result kinds.
  localparam logic [1:0] EV_DELTA   = 2'd0;
  localparam logic [1:0] EV_MOVE    = 2'd1;
  localparam logic [1:0] EV_PRESS   = 2'd2;
  localparam logic [1:0] EV_RELEASE = 2'd3;

  // Configuration register indexes.
  localparam logic REG_BOUND_WIDTH  = 1'b0;
  localparam logic REG_BOUND_HEIGHT = 1'b1;

  // Byte 0 of a PS/2 packet.
  localparam int PS2_SYNC_BIT = 3;
  localparam int PS2_XSIGN_BIT = 4;
  localparam int PS2_YSIGN_BIT = 5;
  localparam int PS2_XOVF_BIT = 6;
  localparam int PS2_YOVF_BIT = 7;

  // Minimum HID report lengths.
  localparam logic [7:0] BOOT_MIN_LEN   = 8'd3;
  localparam logic [7:0] TABLET_MIN_LEN = 8'd5;

  // Tablet full scale is 2^SCALE_SHIFT - 1.
  localparam int SCALE_SHIFT = 15;
  localparam logic [15:0] SCALE_FULL = 16'h7FFF;

  localparam logic signed [15:0] DELTA_MAX = 16'sh7FFF;
  localparam logic signed [15:0] DELTA_MIN = -16'sh8000;

  // A decoded update, after framing.
  typedef struct packed {
    logic                is_abs;
    logic signed [15:0]  dx;
    logic signed [15:0]  dy;
    logic [2:0]          buttons;
    logic [15:0]         ax;
    logic [15:0]         ay;
  } upd_t;

  // An update with tablet targets scaled and clamped.
  typedef struct packed {
    logic                is_abs;
    logic signed [15:0]  dx;
    logic signed [15:0]  dy;
    logic [2:0]          buttons;
    logic [15:0]         tx;
    logic [15:0]         ty;
  } tgt_t;

  // Bound write, as seen by the cursor logic.
  typedef struct packed {
    logic        wr_w;
    logic        wr_h;
    logic [15:0] value;
  } cfg_wr_t;

endpackage

>>> src/mpct_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpct_in_if
// Request channel carrying PS/2 bytes and HID reports.
// ----------------------------------------------------------------------------
interface mpct_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic               from_aux;
  logic [7:0]         data_byte;
  logic [7:0]         report_length;
  logic signed [7:0]  rel_x;
  logic signed [7:0]  rel_y;
  logic [15:0]        abs_x;
  logic [15:0]        abs_y;

  modport source (output valid, func, from_aux, data_byte, report_length, rel_x, rel_y,
                  abs_x, abs_y, input ready);
  modport sink (input valid, func, from_aux, data_byte, report_length, rel_x, rel_y,
                abs_x, abs_y, output ready);
endinterface

>>> src/mpct_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpct_out_if
// Result channel carrying delta records and cursor events.
// ----------------------------------------------------------------------------
interface mpct_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         event_kind;
  logic signed [15:0] delta_x;
  logic signed [15:0] delta_y;
  logic signed [31:0] cursor_x;
  logic signed [31:0] cursor_y;
  logic [2:0]         button_bits;
  logic               last_of_run;

  modport source (output valid, event_kind, delta_x, delta_y, cursor_x, cursor_y,
                  button_bits, last_of_run, input ready);
  modport sink (input valid, event_kind, delta_x, delta_y, cursor_x, cursor_y,
                button_bits, last_of_run, output ready);
endinterface

>>> src/mpct_frame.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpct_frame
// Input register: frames PS/2 packets and decodes HID reports into updates.
// ----------------------------------------------------------------------------
module mpct_frame import mpct_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  mpct_in_if.sink    pkt,
  input  logic       down_free,
  output logic       upd_valid,
  output upd_t       upd
);

  logic [1:0] pos, pos_next;
  logic [7:0] pb0, pb0_next;
  logic [7:0] pb1, pb1_next;
  logic       accept;
  logic       hit;
  upd_t       rec;

  assign pkt.ready = !upd_valid || down_free;
  assign accept = pkt.valid && pkt.ready;

  always_comb begin
    pos_next = pos;
    pb0_next = pb0;
    pb1_next = pb1;
    hit = 1'b0;
    rec.is_abs = 1'b0;
    rec.dx = '0;
    rec.dy = '0;
    rec.buttons = pkt.data_byte[2:0];
    rec.ax = pkt.abs_x;
    rec.ay = pkt.abs_y;
    case (pkt.func)
      FUNC_PS2: begin
        if (pkt.from_aux) begin
          case (pos)
            2'd1: begin
              pb1_next = pkt.data_byte;
              pos_next = 2'd2;
            end
            2'd2: begin
              pos_next = 2'd0;
              hit = pb0[PS2_SYNC_BIT] && !pb0[PS2_XOVF_BIT] && !pb0[PS2_YOVF_BIT];
              rec.dx = {{7{pb0[PS2_XSIGN_BIT]}}, pb0[PS2_XSIGN_BIT], pb1};
              // Y is flipped into screen orientation.
              rec.dy = -$signed({{7{pb0[PS2_YSIGN_BIT]}}, pb0[PS2_YSIGN_BIT],
                                 pkt.data_byte});
              rec.buttons = pb0[2:0];
            end
            default: begin
              // A first byte must carry the sync bit, else framing stays put.
              if (pkt.data_byte[PS2_SYNC_BIT]) begin
                pb0_next = pkt.data_byte;
                pos_next = 2'd1;
              end else begin
                pos_next = 2'd0;
              end
            end
          endcase
        end
      end
      FUNC_BOOT: begin
        hit = pkt.report_length >= BOOT_MIN_LEN;
        rec.dx = {{8{pkt.rel_x[7]}}, pkt.rel_x};
        rec.dy = {{8{pkt.rel_y[7]}}, pkt.rel_y};
      end
      FUNC_TABLET: begin
        hit = pkt.report_length >= TABLET_MIN_LEN;
        rec.is_abs = 1'b1;
      end
      default: hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= 2'd0;
      upd_valid <= 1'b0;
    end else if (accept) begin
      pos <= pos_next;
      upd_valid <= hit;
    end else if (down_free) begin
      upd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pb0 <= pb0_next;
      pb1 <= pb1_next;
      upd <= rec;
    end
  end

endmodule

>>> src/mpct_scale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpct_scale
// Two stages that scale tablet coordinates to the bounds: a multiply by
// bound-1, then a divide by the full scale and a clamp to the bound.
// ----------------------------------------------------------------------------
module mpct_scale import mpct_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        upd_valid,
  input  upd_t        upd,
  output logic        up_free,
  input  logic [15:0] bound_w,
  input  logic [15:0] bound_h,
  output logic        tgt_valid,
  output tgt_t        tgt,
  input  logic        down_ready
);

  logic        v2;
  upd_t        u2;
  logic [31:0] px, py;
  logic        scx, scy;
  logic        s3_free;
  logic [15:0] wm1, hm1;

  // Divides p by 2^15-1 when scaled, using p = a*(2^15-1) + a + b twice,
  // then clamps to bound-1 when the bound is set.
  function automatic logic [15:0] fit_axis(input logic [31:0] p, input logic scaled,
                                           input logic [15:0] bound);
    logic [16:0] a;
    logic [17:0] c;
    logic [2:0]  a2;
    logic [15:0] d;
    logic [17:0] q;
    logic [15:0] bm1;
    a = p[31:SCALE_SHIFT];
    c = {1'b0, a} + {3'b0, p[SCALE_SHIFT-1:0]};
    a2 = c[17:SCALE_SHIFT];
    d = {13'b0, a2} + {1'b0, c[SCALE_SHIFT-1:0]};
    q = {1'b0, a} + {15'b0, a2} + {17'b0, (d >= SCALE_FULL)};
    if (!scaled) q = {2'b0, p[15:0]};
    bm1 = bound - 16'd1;
    if (bound == 16'd0) fit_axis = q[15:0];
    else if (q > {2'b0, bm1}) fit_axis = bm1;
    else fit_axis = q[15:0];
  endfunction

  assign wm1 = bound_w - 16'd1;
  assign hm1 = bound_h - 16'd1;
  assign s3_free = !tgt_valid || down_ready;
  assign up_free = !v2 || s3_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      tgt_valid <= 1'b0;
    end else begin
      if (up_free) v2 <= upd_valid;
      if (s3_free) tgt_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (up_free) begin
      u2 <= upd;
      scx <= bound_w > 16'd1;
      scy <= bound_h > 16'd1;
      px <= (bound_w > 16'd1) ? upd.ax * wm1 : {16'b0, upd.ax};
      py <= (bound_h > 16'd1) ? upd.ay * hm1 : {16'b0, upd.ay};
    end
    if (s3_free) begin
      tgt.is_abs <= u2.is_abs;
      tgt.dx <= u2.dx;
      tgt.dy <= u2.dy;
      tgt.buttons <= u2.buttons;
      tgt.tx <= fit_axis(px, scx, bound_w);
      tgt.ty <= fit_axis(py, scy, bound_h);
    end
  end

endmodule

>>> src/mpct_track.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpct_track
// Cursor and button state, and the result register that plays out the
// delta record and the move, press and release events of each update.
// ----------------------------------------------------------------------------
module mpct_track import mpct_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        tgt_valid,
  input  tgt_t        tgt,
  output logic        tk_ready,
  input  logic [15:0] bound_w,
  input  logic [15:0] bound_h,
  input  cfg_wr_t     cfg,
  mpct_out_if.source  evt
);

  logic [31:0]        cx, cy;
  logic [2:0]         btn;
  logic [3:0]         pend;
  logic [3:0]         pend_rest;
  logic signed [15:0] dx_r, dy_r;
  logic [2:0]         pressed_r, released_r;

  logic               take;
  logic               fire;
  logic [31:0]        nx, ny;
  logic signed [15:0] ndx, ndy;
  logic [2:0]         npress, nrelease;
  logic [3:0]         npend;
  logic [15:0]        cfg_m1;

  function automatic logic [31:0] clamp_rel(input logic [31:0] s, input logic [15:0] bound);
    if (bound == 16'd0) clamp_rel = s;
    else if (s[31]) clamp_rel = '0;
    else if (s > {16'b0, bound - 16'd1}) clamp_rel = {16'b0, bound - 16'd1};
    else clamp_rel = s;
  endfunction

  function automatic logic signed [15:0] abs_delta(input logic [15:0] t,
                                                   input logic [31:0] c);
    logic signed [32:0] diff;
    diff = $signed({17'b0, t}) - $signed({c[31], c});
    if (diff > 33'sd32767) abs_delta = DELTA_MAX;
    else if (diff < -33'sd32768) abs_delta = DELTA_MIN;
    else abs_delta = diff[15:0];
  endfunction

  assign pend_rest = pend & (pend - 4'd1);
  assign fire = evt.valid && evt.ready;
  assign tk_ready = (pend == 4'd0) || (fire && pend_rest == 4'd0);
  assign take = tgt_valid && tk_ready;

  always_comb begin
    if (tgt.is_abs) begin
      nx = {16'b0, tgt.tx};
      ny = {16'b0, tgt.ty};
      ndx = abs_delta(tgt.tx, cx);
      ndy = abs_delta(tgt.ty, cy);
    end else begin
      nx = clamp_rel(cx + {{16{tgt.dx[15]}}, tgt.dx}, bound_w);
      ny = clamp_rel(cy + {{16{tgt.dy[15]}}, tgt.dy}, bound_h);
      ndx = tgt.dx;
      ndy = tgt.dy;
    end
    npress = tgt.buttons & ~btn;
    nrelease = btn & ~tgt.buttons;
    npend = {(nrelease != 3'd0), (npress != 3'd0), (ndx != 16'sd0 || ndy != 16'sd0), 1'b1};
  end

  // Writing a nonzero bound pulls a cursor above it down to bound-1, if no update is taken.
  assign cfg_m1 = cfg.value - 16'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cx <= '0;
      cy <= '0;
      btn <= '0;
      pend <= '0;
    end else begin
      if (take) begin
        cx <= nx;
        cy <= ny;
        btn <= tgt.buttons;
        pend <= npend;
      end else begin
        if (fire) pend <= pend_rest;
        if (cfg.wr_w && cfg.value != 16'd0 && !cx[31] && cx[30:0] > {15'b0, cfg_m1})
          cx <= {16'b0, cfg_m1};
        if (cfg.wr_h && cfg.value != 16'd0 && !cy[31] && cy[30:0] > {15'b0, cfg_m1})
          cy <= {16'b0, cfg_m1};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      dx_r <= ndx;
      dy_r <= ndy;
      pressed_r <= npress;
      released_r <= nrelease;
    end
  end

  always_comb begin
    evt.valid = pend != 4'd0;
    evt.delta_x = dx_r;
    evt.delta_y = dy_r;
    evt.cursor_x = cx;
    evt.cursor_y = cy;
    evt.last_of_run = pend_rest == 4'd0;
    if (pend[0]) begin
      evt.event_kind = EV_DELTA;
      evt.button_bits = btn;
    end else if (pend[1]) begin
      evt.event_kind = EV_MOVE;
      evt.button_bits = btn;
    end else if (pend[2]) begin
      evt.event_kind = EV_PRESS;
      evt.button_bits = pressed_r;
    end else begin
      evt.event_kind = EV_RELEASE;
      evt.button_bits = released_r;
    end
  end

endmodule

>>> src/mouse_packet_cursor_tracker_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mouse_packet_cursor_tracker_top
// PS/2 and HID mouse decoder with a bounded cursor and button events.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake            Carries
//  pkt      in   valid/ready          PS/2 byte or HID boot/tablet report
//  evt      out  valid/ready          delta record, move, press, release
//  apb      in   psel/penable/pwrite  bound_width at 0x0, bound_height at 0x4
//
// A request is taken in every cycle while the four-stage pipeline has room
// (input register, multiply, scale and clamp, cursor and result register).
// A request's first result is offered once it has passed the multiply and
// the scale and clamp stages into the result register, which sets the
// sustained rate: an update gives one to four results, one per cycle while
// evt.ready is high. Reset clears framing, cursor, buttons and bounds.
// A stalled result channel fills the pipeline and then holds pkt.ready low.
// ----------------------------------------------------------------------------
module mouse_packet_cursor_tracker_top import mpct_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  mpct_in_if.sink     pkt,
  mpct_out_if.source  evt,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [15:0] bound_w, bound_h;
  logic        wr;
  cfg_wr_t     cfg;
  logic        upd_valid, up_free;
  upd_t        upd;
  logic        tgt_valid, tk_ready;
  tgt_t        tgt;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;
  assign cfg.wr_w = wr && (paddr[2] == REG_BOUND_WIDTH);
  assign cfg.wr_h = wr && (paddr[2] == REG_BOUND_HEIGHT);
  assign cfg.value = pwdata[15:0];
  assign prdata = (paddr[2] == REG_BOUND_WIDTH) ? {16'b0, bound_w} : {16'b0, bound_h};

  always_ff @(posedge clk) begin
    if (rst) begin
      bound_w <= '0;
      bound_h <= '0;
    end else begin
      if (cfg.wr_w) bound_w <= cfg.value;
      if (cfg.wr_h) bound_h <= cfg.value;
    end
  end

  mpct_frame u_frame (
    .clk       (clk),
    .rst       (rst),
    .pkt       (pkt),
    .down_free (up_free),
    .upd_valid (upd_valid),
    .upd       (upd)
  );

  mpct_scale u_scale (
    .clk        (clk),
    .rst        (rst),
    .upd_valid  (upd_valid),
    .upd        (upd),
    .up_free    (up_free),
    .bound_w    (bound_w),
    .bound_h    (bound_h),
    .tgt_valid  (tgt_valid),
    .tgt        (tgt),
    .down_ready (tk_ready)
  );

  mpct_track u_track (
    .clk       (clk),
    .rst       (rst),
    .tgt_valid (tgt_valid),
    .tgt       (tgt),
    .tk_ready  (tk_ready),
    .bound_w   (bound_w),
    .bound_h   (bound_h),
    .cfg       (cfg),
    .evt       (evt)
  );

endmodule

>>> test/tb_mouse_packet_cursor_tracker_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mouse_packet_cursor_tracker_top
// Drives PS/2 bytes and HID boot and tablet reports into the cursor tracker
// and checks every result against a cursor model kept inside the bench.
// Directed tests cover framing, overflow, short reports and tablet scaling.
// Random traffic runs under several bound settings with idling; a separate
// test holds the result channel in a long stall.
// ----------------------------------------------------------------------------
module tb_mouse_packet_cursor_tracker_top;
  import mpct_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 12;

  typedef struct {
    logic [1:0]        func;
    logic              from_aux;
    logic [7:0]        data_byte;
    logic [7:0]        report_length;
    logic signed [7:0] rel_x;
    logic signed [7:0] rel_y;
    logic [15:0]       abs_x;
    logic [15:0]       abs_y;
  } pointer_req_t;

  typedef struct {
    logic [1:0]         kind;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic [2:0]         bits;
    logic               last;
  } cursor_event_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  mpct_in_if  pkt_ch();
  mpct_out_if evt_ch();

  mouse_packet_cursor_tracker_top dut (
    .clk(clk),
    .rst(rst),
    .pkt(pkt_ch),
    .evt(evt_ch),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // Cursor model state.
  logic [7:0]    framed_bytes [2] = '{default: 8'd0};
  int unsigned   framed_count = 0;
  logic [31:0]   track_x = '0;
  logic [31:0]   track_y = '0;
  logic [2:0]    held_buttons = '0;
  logic [15:0]   width_bound = '0;
  logic [15:0]   height_bound = '0;
  cursor_event_t events_due [$];

  int mismatch_count = 0;
  int src_idle_pct = 30;
  int sink_idle_pct = 30;
  int stall_request = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("mouse_packet_cursor_tracker_top verification failed");
    $finish;
  end

  function automatic logic [31:0] bound_clip(logic [31:0] v, logic [15:0] bound);
    if (bound == 16'd0) return v;
    if (v[31]) return 32'd0;
    if (v > {16'd0, bound} - 32'd1) return {16'd0, bound} - 32'd1;
    return v;
  endfunction

  function automatic logic signed [15:0] sat_delta(longint d);
    if (d < -32768) return DELTA_MIN;
    if (d > 32767) return DELTA_MAX;
    return 16'(d);
  endfunction

  // Commits one update and queues its delta record and events.
  function automatic void emit_update(int dx, int dy, logic [31:0] nx, logic [31:0] ny,
                                      logic [2:0] buttons);
    cursor_event_t ev;
    cursor_event_t batch [$];
    logic [2:0] pressed;
    logic [2:0] released;
    pressed = buttons & ~held_buttons;
    released = held_buttons & ~buttons;
    held_buttons = buttons;
    track_x = nx;
    track_y = ny;
    ev.kind = EV_DELTA;
    ev.dx = 16'(dx);
    ev.dy = 16'(dy);
    ev.cx = nx;
    ev.cy = ny;
    ev.bits = buttons;
    ev.last = 1'b0;
    batch.push_back(ev);
    if (dx != 0 || dy != 0) begin
      ev.kind = EV_MOVE;
      batch.push_back(ev);
    end
    if (pressed != 3'd0) begin
      ev.kind = EV_PRESS;
      ev.bits = pressed;
      batch.push_back(ev);
    end
    if (released != 3'd0) begin
      ev.kind = EV_RELEASE;
      ev.bits = released;
      batch.push_back(ev);
    end
    batch[batch.size() - 1].last = 1'b1;
    foreach (batch[i]) events_due.push_back(batch[i]);
  endfunction

  function automatic void move_relative(int dx, int dy, logic [2:0] buttons);
    emit_update(dx, dy, bound_clip(track_x + 32'(dx), width_bound),
                bound_clip(track_y + 32'(dy), height_bound), buttons);
  endfunction

  function automatic void move_absolute(logic [31:0] nx, logic [31:0] ny,
                                        logic [2:0] buttons);
    logic [31:0] cx;
    logic [31:0] cy;
    cx = bound_clip(nx, width_bound);
    cy = bound_clip(ny, height_bound);
    emit_update(sat_delta(longint'(cx) - longint'($signed(track_x))),
                sat_delta(longint'(cy) - longint'($signed(track_y))), cx, cy, buttons);
  endfunction

  function automatic void take_ps2_byte(logic [7:0] b);
    logic [7:0] head;
    int dx;
    int dy;
    if (framed_count < 2) begin
      // A would-be first byte without the sync bit restarts framing.
      if (framed_count == 0 && !b[PS2_SYNC_BIT]) return;
      framed_bytes[framed_count] = b;
      framed_count++;
      return;
    end
    framed_count = 0;
    head = framed_bytes[0];
    if (head[PS2_XOVF_BIT] || head[PS2_YOVF_BIT]) return;
    dx = int'(framed_bytes[1]) - (head[PS2_XSIGN_BIT] ? 256 : 0);
    dy = -(int'(b) - (head[PS2_YSIGN_BIT] ? 256 : 0));
    move_relative(dx, dy, head[2:0]);
  endfunction

  function automatic void track_cursor(pointer_req_t r);
    logic [31:0] sx;
    logic [31:0] sy;
    case (r.func)
      FUNC_PS2: if (r.from_aux) take_ps2_byte(r.data_byte);
      FUNC_BOOT: if (r.report_length >= BOOT_MIN_LEN)
        move_relative(int'(r.rel_x), int'(r.rel_y), r.data_byte[2:0]);
      FUNC_TABLET: if (r.report_length >= TABLET_MIN_LEN) begin
        sx = (width_bound > 16'd1) ?
             (32'(r.abs_x) * 32'(width_bound - 16'd1)) / 32'(SCALE_FULL) : 32'(r.abs_x);
        sy = (height_bound > 16'd1) ?
             (32'(r.abs_y) * 32'(height_bound - 16'd1)) / 32'(SCALE_FULL) : 32'(r.abs_y);
        move_absolute(sx, sy, r.data_byte[2:0]);
      end
      default: ;
    endcase
  endfunction

  // A nonzero bound pulls a cursor above it down; a negative cursor stays.
  function automatic void set_bound(logic idx, logic [15:0] v);
    if (idx == REG_BOUND_WIDTH) begin
      width_bound = v;
      if (v != 16'd0 && longint'($signed(track_x)) > longint'(v) - 1) track_x = 32'(v) - 32'd1;
    end else begin
      height_bound = v;
      if (v != 16'd0 && longint'($signed(track_y)) > longint'(v) - 1) track_y = 32'(v) - 32'd1;
    end
  endfunction

  function automatic pointer_req_t any_req();
    pointer_req_t r;
    r.func = 2'($urandom_range(3));
    r.from_aux = 1'($urandom_range(1));
    r.data_byte = 8'($urandom_range(255));
    r.report_length = 8'($urandom_range(255));
    r.rel_x = 8'($urandom_range(255));
    r.rel_y = 8'($urandom_range(255));
    r.abs_x = 16'($urandom_range(65535));
    r.abs_y = 16'($urandom_range(65535));
    return r;
  endfunction

  function automatic pointer_req_t ps2_req(logic aux, logic [7:0] b);
    pointer_req_t r;
    r = any_req();
    r.func = FUNC_PS2;
    r.from_aux = aux;
    r.data_byte = b;
    return r;
  endfunction

  function automatic pointer_req_t boot_req(logic [7:0] len, logic [2:0] btn,
                                            logic signed [7:0] rx, logic signed [7:0] ry);
    pointer_req_t r;
    r = any_req();
    r.func = FUNC_BOOT;
    r.report_length = len;
    r.data_byte[2:0] = btn;
    r.rel_x = rx;
    r.rel_y = ry;
    return r;
  endfunction

  function automatic pointer_req_t tablet_req(logic [7:0] len, logic [2:0] btn,
                                              logic [15:0] ax, logic [15:0] ay);
    pointer_req_t r;
    r = any_req();
    r.func = FUNC_TABLET;
    r.report_length = len;
    r.data_byte[2:0] = btn;
    r.abs_x = ax;
    r.abs_y = ay;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      mismatch_count++;
    end
  endfunction

  // Result checker.
  always @(posedge clk) begin : result_check
    cursor_event_t due;
    if (!rst && evt_ch.valid && evt_ch.ready) begin
      if (events_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual kind %0d cursor %0h,%0h",
                 $time, evt_ch.event_kind, evt_ch.cursor_x, evt_ch.cursor_y);
        mismatch_count++;
      end else begin
        due = events_due.pop_front();
        check_field("event_kind", due.kind, evt_ch.event_kind);
        check_field("delta_x", due.dx, evt_ch.delta_x);
        check_field("delta_y", due.dy, evt_ch.delta_y);
        check_field("cursor_x", due.cx, evt_ch.cursor_x);
        check_field("cursor_y", due.cy, evt_ch.cursor_y);
        check_field("button_bits", due.bits, evt_ch.button_bits);
        check_field("last_of_run", due.last, evt_ch.last_of_run);
      end
    end
  end

  // Result channel ready, with random idling and requested long stalls.
  initial begin : result_ready_gen
    int held;
    held = 0;
    evt_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_request > 0) begin
        held = stall_request;
        stall_request = 0;
      end
      if (held > 0) begin
        held--;
        evt_ch.ready <= 1'b0;
      end else begin
        evt_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // Offers one request and returns at the edge where it is accepted.
  task automatic send_req(pointer_req_t r);
    int gap;
    gap = ($urandom_range(99) < src_idle_pct / 1.2) ? $urandom_range(1, 3) : 0;
    if (gap > 0) begin
      pkt_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pkt_ch.valid <= 1'b1;
    pkt_ch.func <= r.func;
    pkt_ch.from_aux <= r.from_aux;
    pkt_ch.data_byte <= r.data_byte;
    pkt_ch.report_length <= r.report_length;
    pkt_ch.rel_x <= r.rel_x;
    pkt_ch.rel_y <= r.rel_y;
    pkt_ch.abs_x <= r.abs_x;
    pkt_ch.abs_y <= r.abs_y;
    do @(posedge clk); while (!pkt_ch.ready);
    track_cursor(r);
  endtask

  task automatic send_ps2_packet(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2);
    send_req(ps2_req(1'b1, b0));
    send_req(ps2_req(1'b1, b1));
    send_req(ps2_req(1'b1, b2));
  endtask

  // Requests that give no result may still be in flight when the queue empties.
  task automatic drain_and_settle();
    pkt_ch.valid <= 1'b0;
    while (events_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_bound(logic idx, logic [15:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    set_bound(idx, v);
  endtask

  task automatic configure_bounds(logic [15:0] w, logic [15:0] h);
    drain_and_settle();
    write_bound(REG_BOUND_WIDTH, w);
    write_bound(REG_BOUND_HEIGHT, h);
  endtask

  task automatic test_boot_reports();
    pointer_req_t r;
    configure_bounds(16'd0, 16'd0);
    send_req(boot_req(8'd2, 3'b111, 8'h05, 8'h05));
    send_req(boot_req(BOOT_MIN_LEN, 3'b111, 8'h7F, 8'h80));
    send_req(boot_req(8'd255, 3'b000, 8'h80, 8'h7F));
    send_req(boot_req(8'd4, 3'b101, 8'h00, 8'h00));
    // Cursor goes below zero and wraps while unbounded.
    send_req(boot_req(8'd3, 3'b010, 8'hFF, 8'h01));
    r = any_req();
    r.func = FUNC_UNUSED;
    send_req(r);
  endtask

  task automatic test_ps2_framing();
    send_req(ps2_req(1'b0, 8'h09));
    send_req(ps2_req(1'b1, 8'h00));
    send_ps2_packet(8'h09, 8'h10, 8'h20);
    send_ps2_packet(8'h3A, 8'h01, 8'hFF);
    send_ps2_packet(8'h4C, 8'h05, 8'h05);
    send_ps2_packet(8'h8F, 8'hFF, 8'h00);
  endtask

  task automatic test_tablet_scaling();
    send_req(tablet_req(8'd4, 3'b001, 16'h1000, 16'h1000));
    send_req(tablet_req(TABLET_MIN_LEN, 3'b001, 16'hFFFF, 16'hFFFF));
    send_req(tablet_req(8'd255, 3'b000, 16'h0000, 16'h0000));
    configure_bounds(16'd640, 16'd480);
    send_req(tablet_req(8'd5, 3'b100, SCALE_FULL, 16'hFFFF));
    configure_bounds(16'd1, 16'd1);
    send_req(tablet_req(8'd6, 3'b010, 16'h1234, 16'h7FFF));
    configure_bounds(16'hFFFF, 16'hFFFF);
    send_req(tablet_req(8'd5, 3'b011, 16'hFFFF, 16'h4000));
  endtask

  // Receiver holds off long enough for the pipeline to fill and stall requests.
  task automatic test_backpressure();
    drain_and_settle();
    src_idle_pct = 0;
    stall_request = 80;
    for (int i = 0; i < 20; i++) begin
      send_req(boot_req(8'd3, (i % 2 == 0) ? 3'b101 : 3'b010,
                        8'($urandom_range(1, 127)), 8'($urandom_range(128, 255))));
    end
    src_idle_pct = 30;
  endtask

  task automatic test_random_traffic();
    logic [15:0] bw [6];
    logic [15:0] bh [6];
    logic [7:0]  b0;
    int pick;
    int sent;
    bw = '{16'd0, 16'hFFFF, 16'd1, 16'd800, 16'($urandom_range(2, 2000)), 16'd0};
    bh = '{16'd0, 16'hFFFF, 16'd1, 16'd600, 16'd0, 16'($urandom_range(2, 2000))};
    for (int p = 0; p < 6; p++) begin
      configure_bounds(bw[p], bh[p]);
      src_idle_pct = (p == 3) ? 0 : 30;
      sink_idle_pct = (p == 3) ? 0 : 30;
      sent = 0;
      while (sent < 16) begin
        pick = $urandom_range(99);
        if (pick < 45) begin
          b0 = 8'($urandom_range(255));
          b0[PS2_SYNC_BIT] = 1'b1;
          if ($urandom_range(9) != 0) b0[PS2_YOVF_BIT:PS2_XOVF_BIT] = 2'b00;
          send_ps2_packet(b0, 8'($urandom_range(255)), 8'($urandom_range(255)));
          sent += 3;
        end else if (pick < 65) begin
          send_req(boot_req(($urandom_range(3) == 0) ? BOOT_MIN_LEN : 8'($urandom_range(3, 255)),
                            3'($urandom_range(7)), 8'($urandom_range(255)),
                            8'($urandom_range(255))));
          sent++;
        end else if (pick < 80) begin
          send_req(tablet_req(($urandom_range(3) == 0) ? TABLET_MIN_LEN :
                              8'($urandom_range(5, 255)), 3'($urandom_range(7)),
                              16'($urandom_range(65535)), 16'($urandom_range(65535))));
          sent++;
        end else begin
          // Noise: stray bytes, short reports and unused sources.
          send_req(any_req());
        end
      end
    end
    src_idle_pct = 30;
    sink_idle_pct = 30;
  endtask

  initial begin
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    pkt_ch.valid <= 1'b0;
    pkt_ch.func <= FUNC_PS2;
    pkt_ch.from_aux <= 1'b0;
    pkt_ch.data_byte <= '0;
    pkt_ch.report_length <= '0;
    pkt_ch.rel_x <= '0;
    pkt_ch.rel_y <= '0;
    pkt_ch.abs_x <= '0;
    pkt_ch.abs_y <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_boot_reports();
    test_ps2_framing();
    test_tablet_scaling();
    test_backpressure();
    test_random_traffic();
    drain_and_settle();
    if (mismatch_count == 0) begin
      $display("mouse_packet_cursor_tracker_top verification clean");
    end else begin
      $display("mouse_packet_cursor_tracker_top verification failed");
    end
    $finish;
  end

endmodule
